/* rtl/selt_pkg.sv */
// shared/exclusive lock table package: sizes, command and status codes, state enum
// no dependencies
package selt_pkg;

  localparam int TableEntries = 64;
  localparam int OwnerSlots   = 32;
  localparam int KeyBits      = 48;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = 6;

  typedef enum logic [2:0] {
    CMD_GET_SHARED  = 3'd0,
    CMD_REL_SHARED  = 3'd1,
    CMD_TRY_EXCL    = 3'd2,
    CMD_REL_EXCL    = 3'd3,
    CMD_UPGRADE     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPDATE,
    S_OUT
  } fsm_t;

endpackage

/* rtl/shared_exclusive_lock_table.sv */
// shared/exclusive row lock table: one request word in, one status word out
// depends on selt_pkg
//
//  channel | signals                              | direction
//  in      | in_valid, in_stall, command/row_key/owner | into block
//  out     | out_valid, out_stall, status/sharer_count | out of block
//
// the result word is registered after the request passes through the key
// scan (the key search walks the key memory one entry per cycle through one
// read port with a registered read), then a read of the row and an update
// that writes it back.
// one request is in flight at a time; a new request is accepted only once
// the previous one is through the update.
// reset clears valid and exclusive bits at once; no clearing pass.
// the result waits in an output register while out_stall is high; the next
// request is accepted once the result register is free or being taken.
module shared_exclusive_lock_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [selt_pkg::KeyBits-1:0] row_key,
  input  logic [4:0]  owner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  sharer_count
);

  localparam int N = selt_pkg::TableEntries;
  localparam int W = selt_pkg::IdxW;
  localparam int K = selt_pkg::KeyBits;
  localparam int O = selt_pkg::OwnerSlots;

  // saturate a bit count to the result field
  function automatic logic [5:0] CntW6(input int n);
    CntW6 = (n > 63) ? 6'd63 : n[5:0];
  endfunction

  // per-entry valid and exclusive flags (reset cleared)
  logic [N-1:0] valid_bits;
  logic [N-1:0] excl_bits;

  // memories
  logic [K-1:0] key_mem [N];
  logic [O-1:0] map_mem [N];
  logic [4:0]   own_mem [N];

  // request registers
  logic [2:0]   cmd_r;
  logic [K-1:0] key_r;
  logic [4:0]   own_r;
  selt_pkg::fsm_t state, state_next;

  // scan bookkeeping
  logic [W:0]   scan_idx;
  logic [K-1:0] key_rd;
  logic         rd_live;
  logic [W-1:0] rd_idx;
  logic         hit;
  logic [W-1:0] hit_idx;
  logic         free_found;
  logic [W-1:0] free_idx;
  logic [O-1:0] map_rd;
  logic [4:0]   own_rd;

  // output register
  logic [1:0]   status_r;
  logic [5:0]   count_r;

  // key memory read port (one entry per cycle) and writes
  logic         key_we;
  logic [W-1:0] wr_idx;
  logic         map_we;
  logic [O-1:0] map_wd;
  logic         own_we;

  always_ff @(posedge clk) begin
    key_rd <= key_mem[scan_idx[W-1:0]];
    map_rd <= map_mem[hit ? hit_idx : free_idx];
    own_rd <= own_mem[hit ? hit_idx : free_idx];
    if (key_we) key_mem[wr_idx] <= key_r;
    if (map_we) map_mem[wr_idx] <= map_wd;
    if (own_we) own_mem[wr_idx] <= own_r;
  end

  assign in_stall  = (state != selt_pkg::S_IDLE) || (out_valid && out_stall);
  assign status       = status_r;
  assign sharer_count = count_r;

  // state register and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= selt_pkg::S_IDLE;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      rd_live <= (state == selt_pkg::S_SCAN) && (scan_idx < (W+1)'(N));
    end
    if (in_valid && !in_stall) begin
      cmd_r <= command;
      key_r <= row_key[K-1:0];
      own_r <= owner;
    end
    rd_idx <= scan_idx[W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      selt_pkg::S_IDLE:   if (in_valid && !in_stall) state_next = selt_pkg::S_SCAN;
      selt_pkg::S_SCAN:   if (scan_idx == (W+1)'(N) && !rd_live) state_next = selt_pkg::S_READ;
      selt_pkg::S_READ:   state_next = selt_pkg::S_UPDATE;
      selt_pkg::S_UPDATE: state_next = selt_pkg::S_IDLE;
      default:            state_next = selt_pkg::S_IDLE;
    endcase
  end

  // scan: compare one key per cycle, remember first hit and first free entry
  always_ff @(posedge clk) begin
    if (state == selt_pkg::S_IDLE) begin
      scan_idx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
      hit_idx <= '0;
      free_idx <= '0;
    end else if (state == selt_pkg::S_SCAN) begin
      if (scan_idx < (W+1)'(N)) scan_idx <= scan_idx + 1'b1;
      if (rd_live) begin
        if (valid_bits[rd_idx] && key_rd == key_r && !hit) begin
          hit <= 1'b1;
          hit_idx <= rd_idx;
        end
        if (!valid_bits[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
      end
    end
  end

  // update: decide on the row and write back
  logic [O-1:0] bit_m;
  logic [O-1:0] cur_map;
  logic         cur_ex;
  logic         own_ok;
  logic [1:0]   st_c;
  logic         v_next, ex_next;
  logic [O-1:0] m_next;
  logic         touch;

  always_comb begin
    own_ok  = 32'(own_r) < O;
    bit_m   = own_ok ? (O'(1) << own_r) : '0;
    cur_ex  = hit && excl_bits[hit_idx];
    cur_map = hit ? map_rd : '0;
    st_c    = selt_pkg::ST_REFUSED;
    wr_idx  = hit ? hit_idx : free_idx;
    v_next  = hit;
    ex_next = cur_ex;
    m_next  = cur_map;
    own_we  = 1'b0;
    key_we  = 1'b0;
    touch   = 1'b0;
    if (own_ok) begin
      case (cmd_r)
        selt_pkg::CMD_GET_SHARED: begin
          if (!cur_ex) begin
            if (!hit && !free_found) st_c = selt_pkg::ST_FULL;
            else begin
              key_we = !hit;
              v_next = 1'b1;
              m_next = cur_map | bit_m;
              touch  = 1'b1;
              st_c   = selt_pkg::ST_OK;
            end
          end
        end
        selt_pkg::CMD_REL_SHARED: begin
          if (hit && (cur_map & bit_m) != '0) begin
            m_next = cur_map & ~bit_m;
            v_next = (m_next != '0) || cur_ex;
            touch  = 1'b1;
            st_c   = selt_pkg::ST_OK;
          end
        end
        selt_pkg::CMD_TRY_EXCL: begin
          if (!hit) begin
            if (!free_found) st_c = selt_pkg::ST_FULL;
            else begin
              key_we  = 1'b1;
              own_we  = 1'b1;
              v_next  = 1'b1;
              ex_next = 1'b1;
              m_next  = '0;
              touch   = 1'b1;
              st_c    = selt_pkg::ST_OK;
            end
          end
        end
        selt_pkg::CMD_REL_EXCL: begin
          if (cur_ex && own_rd == own_r) begin
            v_next  = 1'b0;
            ex_next = 1'b0;
            m_next  = '0;
            touch   = 1'b1;
            st_c    = selt_pkg::ST_OK;
          end
        end
        selt_pkg::CMD_UPGRADE: begin
          if (hit) begin
            if (cur_ex) begin
              if (own_rd == own_r) st_c = selt_pkg::ST_OK;
            end else if (cur_map == bit_m) begin
              m_next  = '0;
              ex_next = 1'b1;
              own_we  = 1'b1;
              touch   = 1'b1;
              st_c    = selt_pkg::ST_OK;
            end
          end
        end
        default: st_c = selt_pkg::ST_REFUSED;
      endcase
    end
    if (!v_next) begin
      ex_next = 1'b0;
      m_next  = '0;
    end
    map_we = (state == selt_pkg::S_UPDATE) && touch;
    if (state != selt_pkg::S_UPDATE) begin
      key_we = 1'b0;
      own_we = 1'b0;
    end
    map_wd = m_next;
  end

  // flag bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      excl_bits  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == selt_pkg::S_UPDATE) begin
        if (touch) begin
          valid_bits[wr_idx] <= v_next;
          excl_bits[wr_idx]  <= ex_next;
        end
        out_valid <= 1'b1;
      end
    end
    if (state == selt_pkg::S_UPDATE) begin
      status_r <= st_c;
      count_r  <= (v_next && !ex_next) ? CntW6($countones(m_next)) : '0;
    end
  end

endmodule
